// ----- design/direct_mapped_writeback_cache_defines.svh -----
// Assertion macros for the direct-mapped write-back cache checker.
// No dependencies; include by bare file name.
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_DEFINES_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_DEFINES_SVH

// Clocked property, switched off while reset is asserted
`define DMWC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property, checked during reset as well
`define DMWC_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/dmwc_pkg.sv -----
// Shared types and constants for the direct-mapped write-back cache.
// No dependencies; imported by every module of the block.
package dmwc_pkg;

	localparam int NUM_LINES_DEF    = 256;
	localparam int BLOCK_WORDS_DEF  = 16;
	localparam int MEMORY_WORDS_DEF = 262144;
	localparam int WORD_BITS_DEF    = 32;

	localparam int ADDR_W    = 18;
	localparam int DATA_W    = 32;
	localparam int LAT_W     = 16;
	localparam int TIME_W    = 32;
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_CACHE_RD_LAT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CACHE_WR_LAT = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MEM_RD_LAT   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MEM_WR_LAT   = 8'd3;

	localparam logic [LAT_W-1:0] CACHE_RD_LAT_RST = 16'd1;
	localparam logic [LAT_W-1:0] CACHE_WR_LAT_RST = 16'd1;
	localparam logic [LAT_W-1:0] MEM_RD_LAT_RST   = 16'd100;
	localparam logic [LAT_W-1:0] MEM_WR_LAT_RST   = 16'd100;

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	typedef struct packed {
		logic [LAT_W-1:0] cache_rd;
		logic [LAT_W-1:0] cache_wr;
		logic [LAT_W-1:0] mem_rd;
		logic [LAT_W-1:0] mem_wr;
	} lat_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} bmem_ctl_t;

endpackage

// ----- design/dmwc_cfg_regs.sv -----
// Latency configuration registers of the write-back cache.
// Depends on dmwc_pkg.
module dmwc_cfg_regs import dmwc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LAT_W-1:0]     cfg_data,
	output lat_t                 lat
);

	lat_t lat_q;

	assign cfg_ready = 1'b1;
	assign lat       = lat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_q.cache_rd <= CACHE_RD_LAT_RST;
			lat_q.cache_wr <= CACHE_WR_LAT_RST;
			lat_q.mem_rd   <= MEM_RD_LAT_RST;
			lat_q.mem_wr   <= MEM_WR_LAT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CACHE_RD_LAT: lat_q.cache_rd <= cfg_data;
				REG_CACHE_WR_LAT: lat_q.cache_wr <= cfg_data;
				REG_MEM_RD_LAT:   lat_q.mem_rd   <= cfg_data;
				REG_MEM_WR_LAT:   lat_q.mem_wr   <= cfg_data;
				default:          lat_q          <= lat_q;
			endcase
		end
	end

endmodule

// ----- design/dmwc_backing.sv -----
// Backing word memory with a per-block written flag and its clearing sweep.
// Depends on dmwc_pkg.
module dmwc_backing import dmwc_pkg::*; #(
	parameter int MEMORY_WORDS = MEMORY_WORDS_DEF,
	parameter int BLOCK_WORDS  = BLOCK_WORDS_DEF,
	parameter int WORD_BITS    = WORD_BITS_DEF,
	localparam int MEM_AW      = $clog2(MEMORY_WORDS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bmem_ctl_t            ctl,
	input  logic [MEM_AW-1:0]    rd_addr,
	output logic [WORD_BITS-1:0] rd_word,
	input  logic [MEM_AW-1:0]    wr_addr,
	input  logic [WORD_BITS-1:0] wr_word,
	output logic                 clear_done
);

	localparam int OFF_W  = $clog2(BLOCK_WORDS);
	localparam int BLK_N  = MEMORY_WORDS / BLOCK_WORDS;
	localparam int BLK_AW = $clog2(BLK_N);

	logic [WORD_BITS-1:0] mem [MEMORY_WORDS];
	logic                 flag_mem [BLK_N];

	logic [WORD_BITS-1:0] word_q;
	logic                 flag_q;
	logic [BLK_AW-1:0]    clr_cnt_q;
	logic                 clear_done_q;

	logic                 flag_we;
	logic [BLK_AW-1:0]    flag_waddr;
	logic                 flag_wdata;

	assign flag_we    = !clear_done_q || ctl.wr_en;
	assign flag_waddr = clear_done_q ? wr_addr[MEM_AW-1:OFF_W] : clr_cnt_q;
	assign flag_wdata = clear_done_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_word;
		end
		if (ctl.rd_en) begin
			word_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (flag_we) begin
			flag_mem[flag_waddr] <= flag_wdata;
		end
		if (ctl.rd_en) begin
			flag_q <= flag_mem[rd_addr[MEM_AW-1:OFF_W]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q    <= '0;
			clear_done_q <= 1'b0;
		end else if (!clear_done_q) begin
			if (clr_cnt_q == BLK_AW'(BLK_N - 1)) begin
				clear_done_q <= 1'b1;
			end else begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	// never-written blocks read as zero
	assign rd_word    = flag_q ? word_q : '0;
	assign clear_done = clear_done_q;

endmodule

// ----- design/dmwc_ctrl.sv -----
// Cache sequencer: tag and line memories, miss handling, time total, result register.
// Depends on dmwc_pkg; drives the backing memory port.
module dmwc_ctrl import dmwc_pkg::*; #(
	parameter int NUM_LINES    = NUM_LINES_DEF,
	parameter int BLOCK_WORDS  = BLOCK_WORDS_DEF,
	parameter int MEMORY_WORDS = MEMORY_WORDS_DEF,
	parameter int WORD_BITS    = WORD_BITS_DEF,
	localparam int MEM_AW      = $clog2(MEMORY_WORDS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic                 command,
	input  logic [ADDR_W-1:0]    word_address,
	input  logic [DATA_W-1:0]    write_word,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic [DATA_W-1:0]    read_word,
	output logic                 was_hit,
	output logic [TIME_W-1:0]    elapsed_time,
	input  lat_t                 lat,
	output bmem_ctl_t            bm_ctl,
	output logic [MEM_AW-1:0]    bm_rd_addr,
	input  logic [WORD_BITS-1:0] bm_rd_word,
	output logic [MEM_AW-1:0]    bm_wr_addr,
	output logic [WORD_BITS-1:0] bm_wr_word,
	input  logic                 bm_clear_done
);

	localparam int OFF_W   = $clog2(BLOCK_WORDS);
	localparam int IDX_W   = $clog2(NUM_LINES);
	localparam int EFF_AW  = (MEM_AW < ADDR_W) ? MEM_AW : ADDR_W;
	localparam int TAG_RAW = EFF_AW - OFF_W - IDX_W;
	localparam int TAG_W   = (TAG_RAW < 1) ? 1 : TAG_RAW;
	localparam int FULL_W  = TAG_W + IDX_W + OFF_W;
	localparam int LINE_AW = IDX_W + OFF_W;
	localparam int SUM_W   = LAT_W + 2;

	typedef struct packed {
		logic             valid;
		logic             dirty;
		logic [TAG_W-1:0] tag;
	} tag_entry_t;

	typedef enum logic [5:0] {
		S_CLEAR  = 6'b000001,
		S_IDLE   = 6'b000010,
		S_LOOKUP = 6'b000100,
		S_WB     = 6'b001000,
		S_FILL   = 6'b010000,
		S_ACCESS = 6'b100000
	} state_t;

	function automatic logic [MEM_AW-1:0] to_mem(input logic [FULL_W-1:0] a);
		logic [FULL_W+MEM_AW-1:0] ext;
		ext = {{MEM_AW{1'b0}}, a};
		return ext[MEM_AW-1:0];
	endfunction

	tag_entry_t           tag_mem [NUM_LINES];
	logic [WORD_BITS-1:0] data_mem [NUM_LINES*BLOCK_WORDS];

	state_t               state_q;
	logic                 is_wr_q;
	logic [IDX_W-1:0]     idx_q;
	logic [OFF_W-1:0]     off_q;
	logic [TAG_W-1:0]     tag_q;
	logic [WORD_BITS-1:0] word_q;
	tag_entry_t           tag_rd_q;
	logic [WORD_BITS-1:0] data_rd_q;
	logic [OFF_W:0]       cnt_q;
	logic                 victim_dirty_q;
	logic [IDX_W-1:0]     clr_cnt_q;
	logic                 wb_v_s1;
	logic [OFF_W-1:0]     wb_off_s1;
	logic                 fill_v_s1;
	logic [OFF_W-1:0]     fill_off_s1;
	logic [WORD_BITS-1:0] fetched_q;
	logic [TIME_W-1:0]    time_q;
	logic                 rsp_valid_q;
	logic [DATA_W-1:0]    read_word_q;
	logic                 was_hit_q;
	logic [TIME_W-1:0]    elapsed_time_q;

	logic [FULL_W+EFF_AW-1:0]    addr_pad;
	logic [DATA_W+WORD_BITS-1:0] wr_pad;
	logic [IDX_W-1:0]            in_idx;
	logic [OFF_W-1:0]            in_off;
	logic [TAG_W-1:0]            in_tag;
	logic [WORD_BITS-1:0]        in_word;
	logic                        accept;
	logic                        out_free;
	logic                        lk_hit;
	logic                        finish;

	logic                 tag_we;
	logic [IDX_W-1:0]     tag_waddr;
	tag_entry_t           tag_wdata;
	logic                 data_re;
	logic [LINE_AW-1:0]   data_raddr;
	logic                 data_we;
	logic [LINE_AW-1:0]   data_waddr;
	logic [WORD_BITS-1:0] data_wdata;

	logic [WORD_BITS-1:0]        rsel;
	logic [DATA_W+WORD_BITS-1:0] rd_pad;
	logic [LAT_W-1:0]            lat_acc;
	logic [LAT_W-1:0]            lat_mrd;
	logic [LAT_W-1:0]            lat_mwr;
	logic [SUM_W-1:0]            lat_sum;
	logic [TIME_W-1:0]           time_next;

	assign addr_pad = {{FULL_W{1'b0}}, word_address[EFF_AW-1:0]};
	assign in_off   = addr_pad[OFF_W-1:0];
	assign in_idx   = addr_pad[OFF_W +: IDX_W];
	assign in_tag   = addr_pad[OFF_W+IDX_W +: TAG_W];
	assign wr_pad   = {{WORD_BITS{1'b0}}, write_word};
	assign in_word  = wr_pad[WORD_BITS-1:0];

	assign req_stall = !((state_q == S_IDLE) && bm_clear_done);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign lk_hit    = tag_rd_q.valid && (tag_rd_q.tag == tag_q);
	assign finish    = out_free &&
		(((state_q == S_LOOKUP) && lk_hit) || (state_q == S_ACCESS));

	always_comb begin
		tag_we    = 1'b0;
		tag_waddr = idx_q;
		tag_wdata = '{valid: 1'b1, dirty: is_wr_q, tag: tag_q};
		case (state_q)
			S_CLEAR: begin
				tag_we    = 1'b1;
				tag_waddr = clr_cnt_q;
				tag_wdata = '0;
			end
			S_LOOKUP: begin
				tag_we = finish && is_wr_q;
			end
			S_ACCESS: begin
				tag_we = finish;
			end
			default: begin
				tag_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[tag_waddr] <= tag_wdata;
		end
		if (accept) begin
			tag_rd_q <= tag_mem[in_idx];
		end
	end

	assign data_re    = accept || (state_q == S_WB);
	assign data_raddr = accept ? {in_idx, in_off} : {idx_q, cnt_q[OFF_W-1:0]};

	always_comb begin
		data_we    = 1'b0;
		data_waddr = {idx_q, off_q};
		data_wdata = word_q;
		if (fill_v_s1) begin
			data_we    = 1'b1;
			data_waddr = {idx_q, fill_off_s1};
			data_wdata = (is_wr_q && (fill_off_s1 == off_q)) ? word_q : bm_rd_word;
		end else if ((state_q == S_LOOKUP) && finish && is_wr_q) begin
			data_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (data_we) begin
			data_mem[data_waddr] <= data_wdata;
		end
		if (data_re) begin
			data_rd_q <= data_mem[data_raddr];
		end
	end

	assign bm_ctl.rd_en = (state_q == S_FILL) && !cnt_q[OFF_W];
	assign bm_ctl.wr_en = wb_v_s1;
	assign bm_rd_addr   = to_mem({tag_q, idx_q, cnt_q[OFF_W-1:0]});
	assign bm_wr_addr   = to_mem({tag_rd_q.tag, idx_q, wb_off_s1});
	assign bm_wr_word   = data_rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_cnt_q      <= '0;
			cnt_q          <= '0;
			victim_dirty_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (clr_cnt_q == IDX_W'(NUM_LINES - 1)) begin
						state_q <= S_IDLE;
					end else begin
						clr_cnt_q <= clr_cnt_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_LOOKUP;
					end
				end
				S_LOOKUP: begin
					if (lk_hit) begin
						if (out_free) begin
							state_q <= S_IDLE;
						end
					end else begin
						cnt_q          <= '0;
						victim_dirty_q <= tag_rd_q.valid && tag_rd_q.dirty;
						state_q        <= (tag_rd_q.valid && tag_rd_q.dirty) ? S_WB : S_FILL;
					end
				end
				S_WB: begin
					if (cnt_q == (OFF_W+1)'(BLOCK_WORDS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_FILL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FILL: begin
					if (cnt_q[OFF_W]) begin
						state_q <= S_ACCESS;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_ACCESS: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_wr_q <= (command == CMD_WRITE);
			idx_q   <= in_idx;
			off_q   <= in_off;
			tag_q   <= in_tag;
			word_q  <= in_word;
		end
		wb_off_s1   <= cnt_q[OFF_W-1:0];
		fill_off_s1 <= cnt_q[OFF_W-1:0];
		if (fill_v_s1 && (fill_off_s1 == off_q)) begin
			fetched_q <= bm_rd_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_v_s1   <= 1'b0;
			fill_v_s1 <= 1'b0;
		end else begin
			wb_v_s1   <= (state_q == S_WB);
			fill_v_s1 <= bm_ctl.rd_en;
		end
	end

	assign rsel    = is_wr_q ? '0 : ((state_q == S_ACCESS) ? fetched_q : data_rd_q);
	assign rd_pad  = {{DATA_W{1'b0}}, rsel};
	assign lat_acc = is_wr_q ? lat.cache_wr : lat.cache_rd;
	assign lat_mrd = (state_q == S_ACCESS) ? lat.mem_rd : '0;
	assign lat_mwr = ((state_q == S_ACCESS) && victim_dirty_q) ? lat.mem_wr : '0;
	assign lat_sum = SUM_W'(lat_acc) + SUM_W'(lat_mrd) + SUM_W'(lat_mwr);
	assign time_next = time_q + TIME_W'(lat_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else if (finish) begin
			time_q      <= time_next;
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			read_word_q    <= rd_pad[DATA_W-1:0];
			was_hit_q      <= (state_q == S_LOOKUP);
			elapsed_time_q <= time_next;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign read_word    = read_word_q;
	assign was_hit      = was_hit_q;
	assign elapsed_time = elapsed_time_q;

endmodule

// ----- design/direct_mapped_writeback_cache.sv -----
// Direct-mapped write-back write-allocate cache. One transfer is taken at a time. A hit
// is accepted into LOOKUP and its result registered there once the output is free; a clean
// miss goes LOOKUP, FILL, ACCESS and a dirty miss LOOKUP, WB, FILL, ACCESS, the block moves
// running at one word per cycle. After reset the line tags and the MEMORY_WORDS / BLOCK_WORDS
// backing block flags (16384 at defaults) are swept clear; no transfer is
// accepted until both sweeps end. Configuration writes are taken at any time.
module direct_mapped_writeback_cache import dmwc_pkg::*; #(
	parameter int NUM_LINES    = NUM_LINES_DEF,
	parameter int BLOCK_WORDS  = BLOCK_WORDS_DEF,
	parameter int MEMORY_WORDS = MEMORY_WORDS_DEF,
	parameter int WORD_BITS    = WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LAT_W-1:0]     cfg_data,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic                 command,
	input  logic [ADDR_W-1:0]    word_address,
	input  logic [DATA_W-1:0]    write_word,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic [DATA_W-1:0]    read_word,
	output logic                 was_hit,
	output logic [TIME_W-1:0]    elapsed_time
);

	localparam int MEM_AW = $clog2(MEMORY_WORDS);

	lat_t                 lat;
	bmem_ctl_t            bm_ctl;
	logic [MEM_AW-1:0]    bm_rd_addr;
	logic [WORD_BITS-1:0] bm_rd_word;
	logic [MEM_AW-1:0]    bm_wr_addr;
	logic [WORD_BITS-1:0] bm_wr_word;
	logic                 bm_clear_done;

	dmwc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.lat       (lat)
	);

	dmwc_backing #(
		.MEMORY_WORDS (MEMORY_WORDS),
		.BLOCK_WORDS  (BLOCK_WORDS),
		.WORD_BITS    (WORD_BITS)
	) u_backing (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (bm_ctl),
		.rd_addr    (bm_rd_addr),
		.rd_word    (bm_rd_word),
		.wr_addr    (bm_wr_addr),
		.wr_word    (bm_wr_word),
		.clear_done (bm_clear_done)
	);

	dmwc_ctrl #(
		.NUM_LINES    (NUM_LINES),
		.BLOCK_WORDS  (BLOCK_WORDS),
		.MEMORY_WORDS (MEMORY_WORDS),
		.WORD_BITS    (WORD_BITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.command       (command),
		.word_address  (word_address),
		.write_word    (write_word),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.read_word     (read_word),
		.was_hit       (was_hit),
		.elapsed_time  (elapsed_time),
		.lat           (lat),
		.bm_ctl        (bm_ctl),
		.bm_rd_addr    (bm_rd_addr),
		.bm_rd_word    (bm_rd_word),
		.bm_wr_addr    (bm_wr_addr),
		.bm_wr_word    (bm_wr_word),
		.bm_clear_done (bm_clear_done)
	);

endmodule

// ----- design/dmwc_port_checker.sv -----
// Port-level checker for the write-back cache, bound to the top level.
// Depends on dmwc_pkg and direct_mapped_writeback_cache_defines.svh.
`include "direct_mapped_writeback_cache_defines.svh"

module dmwc_port_checker import dmwc_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_stall,
	input logic                 rsp_valid,
	input logic                 rsp_stall,
	input logic [DATA_W-1:0]    read_word,
	input logic                 was_hit,
	input logic [TIME_W-1:0]    elapsed_time
);

	logic [1:0] pend_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = req_valid && !req_stall;
	assign out_xfer = rsp_valid && !rsp_stall;

	// count transfers accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else if (in_xfer && !out_xfer) begin
			pend_q <= pend_q + 2'd1;
		end else if (out_xfer && !in_xfer) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	`DMWC_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> (req_stall && !rsp_valid), "busy in reset")
	`DMWC_ASSERT(a_one_at_work, clk, arst_n, in_xfer |=> req_stall, "second request taken")
	`DMWC_ASSERT(a_rsp_hold, clk, arst_n, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(read_word) && $stable(was_hit) && $stable(elapsed_time)), "stalled result changed")
	`DMWC_ASSERT(a_rsp_owed, clk, arst_n, (rsp_valid |-> (pend_q != 2'd0)) and (pend_q != 2'd3), "result without request")

endmodule

bind direct_mapped_writeback_cache dmwc_port_checker u_port_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req_valid),
	.req_stall    (req_stall),
	.rsp_valid    (rsp_valid),
	.rsp_stall    (rsp_stall),
	.read_word    (read_word),
	.was_hit      (was_hit),
	.elapsed_time (elapsed_time)
);
